// ----- hw/rtl/pfa_pkg.sv -----
// shared constants, action and status codes, and controller/datapath structs
// for the page frame allocator; no dependencies
package pfa_pkg;

  localparam int FRAMES_DEF = 4096;
  localparam int GROUP_DEF  = 64;
  localparam int FRAME_W_DEF = 12;

  localparam logic [2:0] ACT_LOCK    = 3'd0;
  localparam logic [2:0] ACT_UNLOCK  = 3'd1;
  localparam logic [2:0] ACT_RESERVE = 3'd2;
  localparam logic [2:0] ACT_FREE    = 3'd3;
  localparam logic [2:0] ACT_INC     = 3'd4;
  localparam logic [2:0] ACT_DEC     = 3'd5;
  localparam logic [2:0] ACT_QUERY   = 3'd6;
  localparam logic [2:0] ACT_UNKNOWN = 3'd7;

  localparam logic [1:0] STS_DONE    = 2'd0;
  localparam logic [1:0] STS_REFUSED = 2'd1;
  localparam logic [1:0] STS_RANGE   = 2'd2;

  localparam logic [7:0] FS_FREE   = 8'h00;
  localparam logic [7:0] FS_LOCKED = 8'hFF;
  localparam logic [7:0] REF_MAX   = 8'd127;

  typedef struct packed {
    logic clr;
    logic load;
    logic check;
    logic rd;
    logic ex;
    logic fv_rd;
    logic out;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic skip;
    logic more;
    logic out_free;
  } sts_t;

endpackage

// ----- hw/rtl/pfa_if.sv -----
// request and result channel interfaces for the page frame allocator
// depends on pfa_pkg
interface pfa_req_if #(parameter int FW = pfa_pkg::FRAME_W_DEF);
  logic          valid;
  logic          ready;
  logic [2:0]    action;
  logic [FW-1:0] frame;
  logic [FW:0]   count;
  modport source (output valid, action, frame, count, input ready);
  modport sink (input valid, action, frame, count, output ready);
endinterface

interface pfa_rsp_if #(parameter int FW = pfa_pkg::FRAME_W_DEF);
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [FW-1:0]     result_frame;
  logic signed [7:0] frame_value;
  logic [FW:0]       reserved_frames;
  logic [FW:0]       used_frames;
  logic [FW:0]       usable_frames;
  modport source (output valid, status, result_frame, frame_value, reserved_frames,
                  used_frames, usable_frames, input ready);
  modport sink (input valid, status, result_frame, frame_value, reserved_frames,
                used_frames, usable_frames, output ready);
endinterface

// ----- hw/rtl/pfa_ram.sv -----
// generic single write, single read ram with registered read data
// no dependencies
module pfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- hw/rtl/pfa_ctrl.sv -----
// sequencer for the page frame allocator: clear sweep, per-frame steps, result
// depends on pfa_pkg
module pfa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  pfa_pkg::sts_t st,
  output pfa_pkg::cmd_t cmd
);
  import pfa_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_RD, S_EX, S_FV_RD, S_OUT
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    req_ready  = 1'b0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (st.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = st.skip ? S_FV_RD : S_RD;
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_EX;
      end
      S_EX: begin
        cmd.ex     = 1'b1;
        state_next = st.more ? S_RD : S_FV_RD;
      end
      S_FV_RD: begin
        cmd.fv_rd  = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        // keep the result frame addressed while the result register is busy
        cmd.fv_rd = 1'b1;
        if (st.out_free) begin
          cmd.out    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end
endmodule

// ----- hw/rtl/pfa_dp.sv -----
// datapath of the page frame allocator: frame and group memories, counters,
// totals, config register and result register; depends on pfa_pkg, pfa_ram
module pfa_dp #(
  parameter int FRAMES = pfa_pkg::FRAMES_DEF,
  parameter int GROUP  = pfa_pkg::GROUP_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  pfa_pkg::cmd_t               cmd,
  output pfa_pkg::sts_t               st,
  input  logic                        cfg_we,
  input  logic [$clog2(FRAMES):0]     cfg_wdata,
  input  logic [2:0]                  req_action,
  input  logic [$clog2(FRAMES)-1:0]   req_frame,
  input  logic [$clog2(FRAMES):0]     req_count,
  input  logic                        rsp_ready,
  output logic                        rsp_valid,
  output logic [1:0]                  rsp_status,
  output logic [$clog2(FRAMES)-1:0]   rsp_frame,
  output logic signed [7:0]           rsp_value,
  output logic [$clog2(FRAMES):0]     rsp_reserved,
  output logic [$clog2(FRAMES):0]     rsp_used,
  output logic [$clog2(FRAMES):0]     rsp_usable
);
  import pfa_pkg::*;

  localparam int FW  = $clog2(FRAMES);
  localparam int CW  = FW + 1;
  localparam int LG  = $clog2(GROUP);
  localparam int BW  = $clog2(GROUP + 1);
  localparam int NG  = FRAMES / GROUP;
  localparam int GAW = (NG > 1) ? $clog2(NG) : 1;

  logic [CW-1:0] total_frames;
  logic [CW-1:0] tot;
  logic [2:0]    act;
  logic [FW-1:0] frm;
  logic [CW-1:0] cnt;
  logic [CW-1:0] frm_x;
  logic [CW-1:0] idx;
  logic [CW-1:0] rem;
  logic [CW-1:0] run;
  logic [CW-1:0] run_next;
  logic          marking;
  logic [FW-1:0] rframe;
  logic [1:0]    code;
  logic [FW-1:0] clr_idx;
  logic [CW-1:0] reserved_total;
  logic [CW-1:0] used_total;

  logic [7:0]    fs;
  logic [BW-1:0] gb;
  logic [FW-1:0] f_raddr;
  logic [FW-1:0] f_waddr;
  logic [7:0]    f_wdata;
  logic          f_we;
  logic [7:0]    fs_wd;
  logic          fs_we;
  logic [BW-1:0] gb_wd;
  logic          gb_we;
  logic [GAW-1:0] g_raddr;
  logic [GAW-1:0] g_waddr;
  logic [BW-1:0]  g_wdata;
  logic           g_we;

  logic bad;
  logic unknown;
  logic skip;
  logic res_up, res_dn, use_up, use_dn;
  logic refuse, found, skip_grp, more;
  logic [BW-1:0] gb_inc, gb_dec;
  logic [CW-1:0] idx_inc;
  logic [CW-1:0] idx_grp;
  logic [CW-1:0] start;

  assign tot   = (total_frames > CW'(FRAMES)) ? CW'(FRAMES) : total_frames;
  assign frm_x = {1'b0, frm};

  // memories
  assign f_raddr = cmd.fv_rd ? rframe : idx[FW-1:0];
  assign g_raddr = GAW'(idx[FW-1:0] >> LG);
  assign f_waddr = cmd.clr ? clr_idx : idx[FW-1:0];
  assign g_waddr = cmd.clr ? GAW'(clr_idx >> LG) : GAW'(idx[FW-1:0] >> LG);
  assign f_wdata = cmd.clr ? FS_FREE : fs_wd;
  assign g_wdata = cmd.clr ? '0 : gb_wd;
  assign f_we    = cmd.clr || (cmd.ex && fs_we);
  assign g_we    = cmd.clr || (cmd.ex && gb_we);

  pfa_ram #(.WIDTH(8), .DEPTH(FRAMES)) u_frame_ram (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(f_raddr), .rdata(fs)
  );

  pfa_ram #(.WIDTH(BW), .DEPTH(NG)) u_group_ram (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
    .raddr(g_raddr), .rdata(gb)
  );

  // request check
  always_comb begin
    bad     = 1'b0;
    unknown = 1'b0;
    skip    = 1'b0;
    case (act)
      ACT_LOCK, ACT_UNLOCK, ACT_FREE: begin
        bad  = (frm_x >= tot) || (cnt > tot - frm_x);
        skip = bad || (cnt == '0);
      end
      ACT_RESERVE: begin
        bad  = (cnt == '0) || (cnt > tot);
        skip = bad;
      end
      ACT_INC, ACT_DEC: begin
        bad  = frm_x >= tot;
        skip = bad;
      end
      ACT_QUERY: begin
        bad  = frm_x >= tot;
        skip = 1'b1;
      end
      default: begin
        unknown = 1'b1;
        skip    = 1'b1;
      end
    endcase
  end

  assign gb_inc  = gb + BW'(1);
  assign gb_dec  = (gb == '0) ? '0 : gb - BW'(1);
  assign idx_inc = idx + CW'(1);
  assign idx_grp = idx + CW'(GROUP);
  assign start   = idx_inc - cnt;

  // one frame step
  always_comb begin
    fs_we    = 1'b0;
    fs_wd    = fs;
    gb_we    = 1'b0;
    gb_wd    = gb;
    res_up   = 1'b0;
    res_dn   = 1'b0;
    use_up   = 1'b0;
    use_dn   = 1'b0;
    refuse   = 1'b0;
    found    = 1'b0;
    skip_grp = 1'b0;
    run_next = run;
    more     = rem != CW'(1);
    if (marking) begin
      fs_we  = 1'b1;
      fs_wd  = 8'd1;
      gb_we  = 1'b1;
      gb_wd  = gb_inc;
      use_up = 1'b1;
    end else begin
      case (act)
        ACT_LOCK: begin
          if (fs != FS_LOCKED) begin
            fs_we  = 1'b1;
            fs_wd  = FS_LOCKED;
            res_up = 1'b1;
            if (fs == FS_FREE) begin
              gb_we = 1'b1;
              gb_wd = gb_inc;
            end else begin
              use_dn = 1'b1;
            end
          end
        end
        ACT_UNLOCK: begin
          if (fs == FS_LOCKED) begin
            fs_we  = 1'b1;
            fs_wd  = FS_FREE;
            gb_we  = 1'b1;
            gb_wd  = gb_dec;
            res_dn = 1'b1;
          end
        end
        ACT_FREE: begin
          if (fs != FS_FREE && fs != FS_LOCKED) begin
            fs_we  = 1'b1;
            fs_wd  = FS_FREE;
            gb_we  = 1'b1;
            gb_wd  = gb_dec;
            use_dn = 1'b1;
          end
        end
        ACT_RESERVE: begin
          // a full group holds no free frame: drop the run and jump over it
          if (idx[LG-1:0] == '0 && gb == BW'(GROUP)) begin
            skip_grp = 1'b1;
            run_next = '0;
            more     = idx_grp < tot;
          end else if (fs == FS_FREE) begin
            run_next = run + CW'(1);
            if (run_next == cnt) begin
              found = 1'b1;
              more  = 1'b1;
            end else begin
              more = idx_inc < tot;
            end
          end else begin
            run_next = '0;
            more     = idx_inc < tot;
          end
          refuse = !more;
        end
        ACT_INC: begin
          more = 1'b0;
          if (fs == FS_FREE || fs == FS_LOCKED) begin
            refuse = 1'b1;
          end else if (cnt <= CW'(REF_MAX - fs)) begin
            fs_we = 1'b1;
            fs_wd = fs + 8'(cnt);
          end else begin
            refuse = 1'b1;
          end
        end
        ACT_DEC: begin
          more = 1'b0;
          if (fs == FS_FREE || fs == FS_LOCKED) begin
            refuse = 1'b1;
          end else if (cnt <= CW'(fs)) begin
            fs_we = 1'b1;
            fs_wd = fs - 8'(cnt);
            if (cnt == CW'(fs)) begin
              gb_we  = 1'b1;
              gb_wd  = gb_dec;
              use_dn = 1'b1;
            end
          end else begin
            refuse = 1'b1;
          end
        end
        default: more = 1'b0;
      endcase
    end
  end

  assign st.skip     = skip;
  assign st.more     = more;
  assign st.clr_last = clr_idx == {FW{1'b1}};
  assign st.out_free = !rsp_valid || rsp_ready;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      total_frames   <= CW'(FRAMES);
      clr_idx        <= '0;
      reserved_total <= '0;
      used_total     <= '0;
      rsp_valid      <= 1'b0;
      marking        <= 1'b0;
    end else begin
      if (cfg_we) total_frames <= cfg_wdata;
      if (cmd.clr) clr_idx <= clr_idx + FW'(1);
      if (cmd.check) marking <= 1'b0;
      if (cmd.ex) begin
        if (found) marking <= 1'b1;
        if (res_up) reserved_total <= reserved_total + CW'(1);
        else if (res_dn && reserved_total != '0) reserved_total <= reserved_total - CW'(1);
        if (use_up) used_total <= used_total + CW'(1);
        else if (use_dn && used_total != '0) used_total <= used_total - CW'(1);
      end
      if (cmd.out) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act <= req_action;
      frm <= req_frame;
      cnt <= req_count;
    end
    if (cmd.check) begin
      idx    <= (act == ACT_RESERVE) ? '0 : frm_x;
      rem    <= cnt;
      run    <= '0;
      rframe <= frm;
      code   <= bad ? STS_RANGE : (unknown ? STS_REFUSED : STS_DONE);
    end
    if (cmd.ex) begin
      run <= run_next;
      if (refuse) code <= STS_REFUSED;
      if (found) begin
        idx    <= start;
        rem    <= cnt;
        rframe <= start[FW-1:0];
      end else begin
        idx <= skip_grp ? idx_grp : idx_inc;
        rem <= rem - CW'(1);
      end
    end
    if (cmd.out) begin
      rsp_status   <= code;
      rsp_frame    <= rframe;
      rsp_value    <= ({1'b0, rframe} < tot) ? fs : 8'sd0;
      rsp_reserved <= reserved_total;
      rsp_used     <= used_total;
      rsp_usable   <= (tot > reserved_total) ? tot - reserved_total : '0;
    end
  end
endmodule

// ----- hw/rtl/page_frame_allocator.sv -----
// page frame allocator top level: controller plus datapath
// query and requests rejected at check go straight to the result, inc/dec take one frame
// step, range actions a read/apply step per frame, reserve a step per scanned frame or
// skipped full group, then one per frame it marks; one request at a time, the next taken
// once the result loads, a held result stalls the sequencer; reset: synchronous,
// clears all frames first and no request is taken until it ends, config always taken
module page_frame_allocator #(
  parameter int FRAMES = pfa_pkg::FRAMES_DEF,
  parameter int GROUP  = pfa_pkg::GROUP_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [$clog2(FRAMES):0] cfg_wdata,
  pfa_req_if.sink                 req,
  pfa_rsp_if.source               rsp
);
  import pfa_pkg::*;

  localparam int CW = $clog2(FRAMES) + 1;

  // command word from the sequencer, status word back from the datapath
  cmd_t cmd;
  sts_t st;

  // sequencer: clear sweep, request check, read/apply steps, result load
  pfa_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .req_valid(req.valid), .req_ready(req.ready),
    .st(st), .cmd(cmd)
  );

  // memories, counters and the result register, which holds a finished
  // word while the next request is already taken
  pfa_dp #(.FRAMES(FRAMES), .GROUP(GROUP)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .req_action(req.action), .req_frame(req.frame), .req_count(req.count),
    .rsp_ready(rsp.ready), .rsp_valid(rsp.valid),
    .rsp_status(rsp.status), .rsp_frame(rsp.result_frame),
    .rsp_value(rsp.frame_value), .rsp_reserved(rsp.reserved_frames),
    .rsp_used(rsp.used_frames), .rsp_usable(rsp.usable_frames)
  );

`ifndef SYNTH
  // only one request in flight
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken while busy");

  // locked plus used frames never exceed the frame count
  a_totals: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (({1'b0, rsp.reserved_frames} + {1'b0, rsp.used_frames})
                   <= (CW + 1)'(FRAMES)))
    else $error("frame totals overflow");

  // status code is always a defined one
  a_status: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.status == STS_DONE || rsp.status == STS_REFUSED ||
                   rsp.status == STS_RANGE))
    else $error("bad status code");
`endif
endmodule

// ----- verif/pfa_scoreboard.sv -----
// frame allocator expectation tracker: mirrors frame states and totals,
// predicts one result word per request; depends on pfa_pkg
`timescale 1ns / 1ps

class pfa_scoreboard;
  typedef struct packed {
    logic [1:0]        status;
    logic [11:0]       rframe;
    logic signed [7:0] fv;
    logic [12:0]       rsv;
    logic [12:0]       used;
    logic [12:0]       usable;
  } outcome_t;

  logic [7:0]  frame_st[4096];
  int unsigned rsv_total;
  int unsigned used_total;
  int unsigned total_frames;
  outcome_t    pending[$];
  int          errors;
  int          checked;

  function new();
    foreach (frame_st[i]) frame_st[i] = pfa_pkg::FS_FREE;
    rsv_total = 0;
    used_total = 0;
    total_frames = 4096;
    errors = 0;
    checked = 0;
  endfunction

  function int unsigned managed();
    return (total_frames > 4096) ? 4096 : total_frames;
  endfunction

  // predict the result of one accepted request and update the mirror
  function void note_request(logic [2:0] act, logic [11:0] frm, logic [12:0] cnt);
    int unsigned tot;
    int unsigned f;
    int unsigned run;
    int unsigned s;
    int          hit;
    outcome_t    o;
    tot = managed();
    o = '0;
    o.status = pfa_pkg::STS_DONE;
    o.rframe = frm;
    if (act == pfa_pkg::ACT_LOCK || act == pfa_pkg::ACT_UNLOCK || act == pfa_pkg::ACT_FREE) begin
      if (frm >= tot || cnt > tot - frm) begin
        o.status = pfa_pkg::STS_RANGE;
      end else begin
        for (int i = 0; i < cnt; i++) begin
          f = frm + i;
          s = frame_st[f];
          if (act == pfa_pkg::ACT_LOCK) begin
            if (s != pfa_pkg::FS_LOCKED) begin
              if (s != 0 && used_total > 0) used_total--;
              frame_st[f] = pfa_pkg::FS_LOCKED;
              rsv_total++;
            end
          end else if (act == pfa_pkg::ACT_UNLOCK) begin
            if (s == pfa_pkg::FS_LOCKED) begin
              frame_st[f] = pfa_pkg::FS_FREE;
              if (rsv_total > 0) rsv_total--;
            end
          end else if (s != 0 && s != pfa_pkg::FS_LOCKED) begin
            frame_st[f] = pfa_pkg::FS_FREE;
            if (used_total > 0) used_total--;
          end
        end
      end
    end else if (act == pfa_pkg::ACT_RESERVE) begin
      if (cnt == 0 || cnt > tot) begin
        o.status = pfa_pkg::STS_RANGE;
      end else begin
        // first fit over managed frames
        run = 0;
        hit = -1;
        for (int i = 0; i < tot; i++) begin
          run = (frame_st[i] == pfa_pkg::FS_FREE) ? run + 1 : 0;
          if (run == cnt) begin
            hit = i + 1 - cnt;
            break;
          end
        end
        if (hit >= 0) begin
          for (int i = 0; i < cnt; i++) frame_st[hit + i] = 8'd1;
          used_total += cnt;
          o.rframe = 12'(hit);
        end else begin
          o.status = pfa_pkg::STS_REFUSED;
        end
      end
    end else if (act <= pfa_pkg::ACT_QUERY) begin
      if (frm >= tot) begin
        o.status = pfa_pkg::STS_RANGE;
      end else if (act != pfa_pkg::ACT_QUERY) begin
        s = frame_st[frm];
        if (s == 0 || s == pfa_pkg::FS_LOCKED) begin
          o.status = pfa_pkg::STS_REFUSED;
        end else if (act == pfa_pkg::ACT_INC) begin
          if (cnt <= pfa_pkg::REF_MAX - s) frame_st[frm] = 8'(s + cnt);
          else o.status = pfa_pkg::STS_REFUSED;
        end else if (cnt <= s) begin
          frame_st[frm] = 8'(s - cnt);
          if (s == cnt && used_total > 0) used_total--;
        end else begin
          o.status = pfa_pkg::STS_REFUSED;
        end
      end
    end else begin
      o.status = pfa_pkg::STS_REFUSED;
    end
    o.fv = (o.rframe < tot) ? frame_st[o.rframe] : 8'sd0;
    o.rsv = 13'(rsv_total);
    o.used = 13'(used_total);
    o.usable = 13'((tot > rsv_total) ? tot - rsv_total : 0);
    pending.push_back(o);
  endfunction

  // compare one accepted result word; returns a message when it differs
  function string check_result(outcome_t got);
    outcome_t w;
    checked++;
    if (pending.size() == 0) return "result word with nothing pending";
    w = pending.pop_front();
    if (got.status !== w.status) return $sformatf("status %0d want %0d", got.status, w.status);
    if (got.rframe !== w.rframe) return $sformatf("frame %0d want %0d", got.rframe, w.rframe);
    if (got.fv !== w.fv) return $sformatf("value %0d want %0d", got.fv, w.fv);
    if (got.rsv !== w.rsv) return $sformatf("reserved %0d want %0d", got.rsv, w.rsv);
    if (got.used !== w.used) return $sformatf("used %0d want %0d", got.used, w.used);
    if (got.usable !== w.usable) return $sformatf("usable %0d want %0d", got.usable, w.usable);
    return "";
  endfunction
endclass

// ----- verif/testbench.sv -----
// top-level bench for page_frame_allocator: drives requests and config,
// checks each result word; depends on pfa_pkg, pfa_if and pfa_scoreboard
`timescale 1ns / 1ps

module testbench;
  import pfa_pkg::*;

  localparam int LIMIT = 20_000_000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [12:0] cfg_wdata;
  int          cycle;
  int          send_idle;  // percent of cycles the sender holds off
  int          recv_stall; // percent of cycles the receiver stalls
  int          failures;
  int          accepted;

  pfa_req_if req ();
  pfa_rsp_if rsp ();

  page_frame_allocator u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .req      (req.sink),
    .rsp      (rsp.source)
  );

  pfa_scoreboard board = new();

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // one line per mismatch, counted
  task automatic report(string msg);
    failures++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // cycle limit guards against a hung handshake
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > LIMIT) begin
      $display("timeout at cycle %0d", cycle);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // sample result words at the rising edge
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      string m;
      m = board.check_result({rsp.status, rsp.result_frame, rsp.frame_value,
                              rsp.reserved_frames, rsp.used_frames, rsp.usable_frames});
      if (m != "") report(m);
    end
  end

  // receiver backpressure, updated on the falling edge
  always @(negedge clk) begin
    rsp.ready <= ($urandom_range(99) >= recv_stall);
  end

  // send one request word, idling first at random
  task automatic send(logic [2:0] act, logic [11:0] frm, logic [12:0] cnt);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) @(negedge clk);
    req.valid  <= 1'b1;
    req.action <= act;
    req.frame  <= frm;
    req.count  <= cnt;
    // wait for acceptance at a rising edge
    do @(posedge clk); while (!req.ready);
    board.note_request(act, frm, cnt);
    accepted++;
    @(negedge clk);
    req.valid <= 1'b0;
  endtask

  // let all pending words drain, then a margin for the block to settle
  task automatic drain();
    while (board.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // config write only while idle
  task automatic set_total(logic [12:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.total_frames = v;
  endtask

  // random request: mostly well-formed ranges inside a small window so
  // that ranges, runs and reference counts interact
  task automatic random_word(int unsigned span);
    logic [2:0]  act;
    logic [11:0] frm;
    logic [12:0] cnt;
    int unsigned r;
    r = $urandom_range(99);
    act = 3'($urandom_range(6));
    frm = 12'($urandom_range(span - 1));
    cnt = 13'($urandom_range(8));
    if (act == ACT_INC || act == ACT_DEC) cnt = 13'($urandom_range(r < 10 ? 130 : 4));
    if (r < 5) begin
      act = ACT_UNKNOWN;
    end else if (r < 12) begin
      frm = 12'($urandom());  // wide noise
      cnt = 13'($urandom());
    end else if (r < 15) begin
      cnt = 13'($urandom_range(4096, 8191));
    end
    send(act, frm, cnt);
  endtask

  initial begin
    int unsigned tots[5];
    cycle      = 0;
    failures   = 0;
    accepted   = 0;
    send_idle  = 0;
    recv_stall = 0;
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    req.valid  = 1'b0;
    req.action = ACT_QUERY;
    req.frame  = '0;
    req.count  = '0;
    rsp.ready  = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, every action, special cases
    send(ACT_QUERY, 12'd4095, 13'd0);
    send(ACT_RESERVE, 12'd0, 13'd4096);     // whole memory
    send(ACT_RESERVE, 12'd0, 13'd1);        // no run found
    send(ACT_FREE, 12'd0, 13'd4096);
    send(ACT_RESERVE, 12'd0, 13'd0);        // empty run
    send(ACT_RESERVE, 12'd0, 13'd8191);     // oversized run
    send(ACT_LOCK, 12'd4095, 13'd2);        // range past end
    send(ACT_LOCK, 12'd10, 13'd0);          // empty range
    send(ACT_RESERVE, 12'd5, 13'd3);
    send(ACT_INC, 12'd0, 13'd126);          // up to the bound
    send(ACT_INC, 12'd0, 13'd1);            // beyond bound
    send(ACT_DEC, 12'd1, 13'd2);            // more than held
    send(ACT_DEC, 12'd1, 13'd1);            // reaches zero
    send(ACT_INC, 12'd1, 13'd1);            // not used
    send(ACT_LOCK, 12'd0, 13'd4);           // locks used frames
    send(ACT_INC, 12'd0, 13'd1);            // locked target
    send(ACT_UNLOCK, 12'd0, 13'd8);
    send(ACT_LOCK, 12'd4000, 13'd96);
    send(ACT_DEC, 12'd4095, 13'd8191);
    send(ACT_UNKNOWN, 12'hFFF, 13'h1FFF);   // unknown action
    set_total(13'd8191);                    // above the frame count
    send(ACT_QUERY, 12'd4095, 13'd0);
    set_total(13'd0);                       // nothing managed
    send(ACT_RESERVE, 12'd0, 13'd1);
    send(ACT_QUERY, 12'd0, 13'd0);
    set_total(13'd1);
    send(ACT_RESERVE, 12'd0, 13'd1);
    send(ACT_FREE, 12'd0, 13'd1);
    set_total(13'd3000);                    // below frames still locked
    send(ACT_QUERY, 12'd2999, 13'd0);
    set_total(13'd4096);
    send(ACT_UNLOCK, 12'd0, 13'd4096);
    send(ACT_FREE, 12'd0, 13'd4096);

    // random phases across idling mixes and register settings
    tots = '{13'd4096, 13'd64, 13'd130, 13'd4096, 13'd1000};
    for (int p = 0; p < 5; p++) begin
      set_total(13'(tots[p]));
      case (p % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 57; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 57; end
        default: begin send_idle = 18; recv_stall = 18; end
      endcase
      for (int i = 0; i < 80; i++)
        random_word(p == 3 ? ((i % 20 == 0) ? 4096 : 200) : (tots[p] + 8));
    end

    drain();
    $display("covered %0d requests over %0d result words, five register settings",
             accepted, board.checked);
    $display("idle mixes: none, sender, receiver, both");
    if (failures == 0 && board.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// ----- page_frame_allocator.f -----
hw/rtl/pfa_pkg.sv
hw/rtl/pfa_if.sv
hw/rtl/pfa_ram.sv
hw/rtl/pfa_ctrl.sv
hw/rtl/pfa_dp.sv
hw/rtl/page_frame_allocator.sv
verif/pfa_scoreboard.sv
verif/testbench.sv
